[rtl/core/ucrh_pkg.sv]
`default_nettype none

package ucrh_pkg;

	// Device state codes
	typedef enum logic [2:0] {
		ST_POWERED    = 3'd0,
		ST_DEFAULT    = 3'd1,
		ST_PENDING    = 3'd2,
		ST_ADDRESS    = 3'd3,
		ST_CONFIGURED = 3'd4
	} dev_state_t;

	// Response codes
	typedef enum logic [1:0] {
		RSP_STALL   = 2'd0,
		RSP_ACK     = 2'd1,
		RSP_DATA    = 2'd2,
		RSP_HANDOFF = 2'd3
	} rsp_code_t;

	// Event kinds
	localparam logic [1:0] EV_SETUP       = 2'd0;
	localparam logic [1:0] EV_BUS_RESET   = 2'd1;
	localparam logic [1:0] EV_STATUS_DONE = 2'd2;

	// Setup request type
	localparam logic [1:0] SETUP_STANDARD = 2'd0;

	// Recipients
	localparam logic [1:0] RCP_DEVICE    = 2'd0;
	localparam logic [1:0] RCP_INTERFACE = 2'd1;
	localparam logic [1:0] RCP_ENDPOINT  = 2'd2;

	// Standard request codes
	localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
	localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
	localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

	// One incoming event
	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  setup_type;
		logic        to_host;
		logic [1:0]  recipient;
		logic [7:0]  request_code;
		logic [15:0] value_word;
		logic [15:0] index_word;
		logic [15:0] length_word;
	} req_t;

	// One result
	typedef struct packed {
		rsp_code_t   response;
		logic [1:0]  reply_length;
		logic [15:0] reply_data;
		dev_state_t  device_state_out;
		logic [6:0]  device_address;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/core/ucrh_if.sv]
`default_nettype none

// Event channel
interface ucrh_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [1:0]  setup_type;
	logic        to_host;
	logic [1:0]  recipient;
	logic [7:0]  request_code;
	logic [15:0] value_word;
	logic [15:0] index_word;
	logic [15:0] length_word;

	modport source (
		output valid, req_type, setup_type, to_host, recipient,
		       request_code, value_word, index_word, length_word,
		input  ready
	);
	modport sink (
		input  valid, req_type, setup_type, to_host, recipient,
		       request_code, value_word, index_word, length_word,
		output ready
	);
endinterface

// Result channel
interface ucrh_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  response;
	logic [1:0]  reply_length;
	logic [15:0] reply_data;
	logic [2:0]  device_state_out;
	logic [6:0]  device_address;

	modport source (
		output valid, response, reply_length, reply_data,
		       device_state_out, device_address,
		input  ready
	);
	modport sink (
		input  valid, response, reply_length, reply_data,
		       device_state_out, device_address,
		output ready
	);
endinterface

`default_nettype wire

[rtl/core/ucrh_in_stage.sv]
`default_nettype none

module ucrh_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	ucrh_req_if.sink          req,
	input  wire logic         advance,
	output logic              valid_s1,
	output ucrh_pkg::req_t    item_s1
);
	import ucrh_pkg::*;

	// Take a new event whenever the stage is empty or is handing on this cycle
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload register
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{
				req_type:     req.req_type,
				setup_type:   req.setup_type,
				to_host:      req.to_host,
				recipient:    req.recipient,
				request_code: req.request_code,
				value_word:   req.value_word,
				index_word:   req.index_word,
				length_word:  req.length_word
			};
		end
	end

endmodule

`default_nettype wire

[rtl/core/ucrh_decode.sv]
`default_nettype none

module ucrh_decode (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic         cfg_wdata,
	input  wire logic         step,
	input  wire ucrh_pkg::req_t item,
	output ucrh_pkg::rsp_t    result
);
	import ucrh_pkg::*;

	dev_state_t  state_q, state_d;
	logic [6:0]  pend_addr_q, pend_addr_d;
	logic        active_cfg_q, active_cfg_d;
	logic        self_powered_q;

	rsp_code_t   rsp;
	logic        is_data;
	logic [1:0]  nat_len;
	logic [15:0] bytes;
	logic [1:0]  len;
	logic [15:0] data;
	logic        addr_or_cfg;

	assign addr_or_cfg = (state_q == ST_ADDRESS) || (state_q == ST_CONFIGURED);

	// Request decode and next state
	always_comb begin
		rsp          = RSP_ACK;
		is_data      = 1'b0;
		nat_len      = 2'd0;
		bytes        = 16'h0000;
		state_d      = state_q;
		pend_addr_d  = pend_addr_q;
		active_cfg_d = active_cfg_q;
		unique case (item.req_type)
			EV_BUS_RESET: begin
				state_d      = ST_DEFAULT;
				pend_addr_d  = 7'd0;
				active_cfg_d = 1'b0;
			end
			EV_STATUS_DONE: begin
				if (state_q == ST_PENDING)
					state_d = (pend_addr_q != 7'd0) ? ST_ADDRESS : ST_DEFAULT;
			end
			EV_SETUP: begin
				rsp = RSP_STALL;
				if (item.setup_type == SETUP_STANDARD) begin
					unique case (item.request_code)
						REQ_GET_STATUS: begin
							if (item.to_host) begin
								if (item.recipient == RCP_DEVICE) begin
									is_data = 1'b1;
									nat_len = 2'd2;
									bytes   = {15'd0, self_powered_q};
								end else if (item.recipient == RCP_INTERFACE ||
								             item.recipient == RCP_ENDPOINT) begin
									is_data = 1'b1;
									nat_len = 2'd2;
								end
							end
						end
						REQ_SET_ADDRESS: begin
							if (item.recipient == RCP_DEVICE &&
							    item.value_word[15:7] == 9'd0 &&
							    (state_q == ST_DEFAULT || state_q == ST_ADDRESS)) begin
								pend_addr_d = item.value_word[6:0];
								state_d     = ST_PENDING;
								rsp         = RSP_ACK;
							end
						end
						REQ_GET_DESCRIPTOR: begin
							if (item.to_host && item.recipient == RCP_DEVICE &&
							    state_q != ST_POWERED && state_q != ST_PENDING)
								rsp = RSP_HANDOFF;
						end
						REQ_GET_CONFIGURATION: begin
							if (item.to_host && item.recipient == RCP_DEVICE && addr_or_cfg) begin
								is_data = 1'b1;
								nat_len = 2'd1;
								bytes   = {15'd0, active_cfg_q};
							end
						end
						REQ_SET_CONFIGURATION: begin
							if (item.recipient == RCP_DEVICE && addr_or_cfg &&
							    item.value_word[7:1] == 7'd0) begin
								active_cfg_d = item.value_word[0];
								state_d      = item.value_word[0] ? ST_CONFIGURED : ST_ADDRESS;
								rsp          = RSP_ACK;
							end
						end
						REQ_GET_INTERFACE: begin
							if (item.to_host && item.recipient == RCP_INTERFACE &&
							    state_q == ST_CONFIGURED && item.index_word[15:1] == 15'd0) begin
								is_data = 1'b1;
								nat_len = 2'd1;
								bytes   = {15'd0, item.index_word[0]};
							end
						end
						REQ_SET_INTERFACE: begin
							if (item.recipient == RCP_INTERFACE &&
							    state_q == ST_CONFIGURED && item.index_word[15:1] == 15'd0)
								rsp = RSP_ACK;
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Data reply length is capped by wLength; bytes past it read as zero
	always_comb begin
		len  = 2'd0;
		data = 16'h0000;
		if (is_data) begin
			len = (item.length_word < {14'd0, nat_len}) ? item.length_word[1:0] : nat_len;
			unique case (len)
				2'd0:    data = 16'h0000;
				2'd1:    data = {8'h00, bytes[7:0]};
				default: data = bytes;
			endcase
		end
	end

	assign result = '{
		response:         is_data ? RSP_DATA : rsp,
		reply_length:     len,
		reply_data:       data,
		device_state_out: state_d,
		device_address:   pend_addr_d
	};

	// Device state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_POWERED;
			pend_addr_q  <= 7'd0;
			active_cfg_q <= 1'b0;
		end else if (step) begin
			state_q      <= state_d;
			pend_addr_q  <= pend_addr_d;
			active_cfg_q <= active_cfg_d;
		end
	end

	// Self-powered register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_powered_q <= 1'b1;
		end else if (cfg_we) begin
			self_powered_q <= cfg_wdata;
		end
	end

`ifndef SYNTHESIS
	a_cfg_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		active_cfg_q == (state_q == ST_CONFIGURED))
		else $error("active configuration disagrees with device state");

	a_bus_reset: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.req_type == EV_BUS_RESET |=>
		state_q == ST_DEFAULT && pend_addr_q == 7'd0 && !active_cfg_q)
		else $error("bus reset did not return to default state");
`endif

endmodule

`default_nettype wire

[rtl/core/ucrh_out_stage.sv]
`default_nettype none

module ucrh_out_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire ucrh_pkg::rsp_t result,
	output logic                stall,
	ucrh_rsp_if.source          rsp
);
	import ucrh_pkg::*;

	logic valid_q;
	rsp_t rsp_q;

	// Full and not being drained: the decode stage must hold
	assign stall = valid_q && !rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid            = valid_q;
	assign rsp.response         = rsp_q.response;
	assign rsp.reply_length     = rsp_q.reply_length;
	assign rsp.reply_data       = rsp_q.reply_data;
	assign rsp.device_state_out = rsp_q.device_state_out;
	assign rsp.device_address   = rsp_q.device_address;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !valid_q || rsp.ready)
		else $error("result overwritten before transfer");

	a_quiet_nondata: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && rsp_q.response != RSP_DATA |->
		rsp_q.reply_length == 2'd0 && rsp_q.reply_data == 16'h0000)
		else $error("reply fields set outside a data reply");
`endif

endmodule

`default_nettype wire

[rtl/core/usb_control_request_handler.sv]
`default_nettype none

// USB chapter 9 standard request handler. Each transfer on req carries one
// event (setup packet, bus reset or status stage done) and yields exactly one
// transfer on rsp, in order. An event is registered on input, decoded
// combinationally against the device state and written to the result
// register; one event is taken every cycle while rsp keeps up, the device
// state register being updated as each event moves on. While a result waits
// on rsp, one more event can enter the input register; after that req is
// held off until the result is taken. Device descriptor requests to the host
// outside the powered and pending states return the hand-off code.
// self_powered (cfg_we/cfg_wdata, reset 1) is bit zero of the device
// Get_Status reply and should be written only while the block is idle.
module usb_control_request_handler (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	ucrh_req_if.sink  req,
	ucrh_rsp_if.source rsp
);
	import ucrh_pkg::*;

	logic valid_s1;
	req_t item_s1;
	rsp_t result;
	logic out_stall;
	logic advance;

	// Move the registered event into the result register
	assign advance = valid_s1 && !out_stall;

	ucrh_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ucrh_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.result    (result)
	);

	ucrh_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance),
		.result (result),
		.stall  (out_stall),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire
